// ----- hdl/tpbc_pkg.sv -----
// Types, codes and reset values shared by the two-phase barrier controller.
// No dependencies.
package tpbc_pkg;

  // register map
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [1:0]  REG_NODE_ID    = 2'd0;
  localparam logic [1:0]  REG_NODE_COUNT = 2'd1;
  localparam logic [1:0]  REG_TIMEOUT    = 2'd2;

  localparam logic [3:0]  RST_NODE_ID    = 4'd0;
  localparam logic [4:0]  RST_NODE_COUNT = 5'd16;
  localparam logic [31:0] RST_TIMEOUT    = 32'd1000000;

  // depth of each decoupling queue
  localparam int unsigned Q_DEPTH = 2;

  // input kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_MSG   = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] KIND_SEND  = 2'd3;

  localparam logic ACT_REQUEST = 1'b0;
  localparam logic ACT_FINISH  = 1'b1;
  localparam logic MSG_ANN     = 1'b0;
  localparam logic MSG_ACK     = 1'b1;

  localparam logic [1:0] CAUSE_NONE    = 2'd0;
  localparam logic [1:0] CAUSE_SEND    = 2'd1;
  localparam logic [1:0] CAUSE_TIMEOUT = 2'd2;

  typedef enum logic [1:0] {
    OP_START,
    OP_MSG,
    OP_TICK,
    OP_SEND
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SEND_ANN,
    PH_COLL_ANN,
    PH_SEND_ACK,
    PH_COLL_ACK
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] epoch;
    logic [3:0]  sender;
    logic        message_type;
    logic        send_ok;
  } in_item_t;

  typedef struct packed {
    logic        action;
    logic        broadcast_type;
    logic [31:0] broadcast_epoch;
    logic        success;
    logic [1:0]  fail_cause;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] epoch;
    logic [3:0]  sender;
    logic        message_type;
    logic        send_ok;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  node_id;
    logic [4:0]  node_count;
    logic [31:0] timeout_ticks;
  } cfg_t;

endpackage

// ----- hdl/tpbc_fifo.sv -----
// Small register queue used between the front, the back and the result port.
// No dependencies.
module tpbc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- hdl/tpbc_cfg.sv -----
// APB-style configuration registers of the barrier controller.
// Depends on tpbc_pkg.
module tpbc_cfg
  import tpbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t       cfg_r, cfg_nxt;
  logic [1:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_NODE_ID:    cfg_nxt.node_id       = pwdata[3:0];
        REG_NODE_COUNT: cfg_nxt.node_count    = pwdata[4:0];
        REG_TIMEOUT:    cfg_nxt.timeout_ticks = pwdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_NODE_ID:    prdata = {28'd0, cfg_r.node_id};
      REG_NODE_COUNT: prdata = {27'd0, cfg_r.node_count};
      REG_TIMEOUT:    prdata = cfg_r.timeout_ticks;
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_id       <= RST_NODE_ID;
      cfg_r.node_count    <= RST_NODE_COUNT;
      cfg_r.timeout_ticks <= RST_TIMEOUT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- hdl/tpbc_front.sv -----
// Front end: takes input beats, decodes the kind and queues commands.
// Depends on tpbc_pkg and tpbc_fifo.
module tpbc_front
  import tpbc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_data,
  input  logic     cmd_pop,
  output logic     cmd_valid,
  output cmd_t     cmd
);

  cmd_t dec;
  logic q_empty;

  always_comb begin
    dec.epoch        = in_data.epoch;
    dec.sender       = in_data.sender;
    dec.message_type = in_data.message_type;
    dec.send_ok      = in_data.send_ok;
    case (in_data.kind)
      KIND_START: dec.op = OP_START;
      KIND_MSG:   dec.op = OP_MSG;
      KIND_TICK:  dec.op = OP_TICK;
      KIND_SEND:  dec.op = OP_SEND;
      default:    dec.op = OP_TICK;
    endcase
  end

  tpbc_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(Q_DEPTH)
  ) u_cmd_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (push),
    .wr_data(dec),
    .full   (full),
    .rd_en  (cmd_pop),
    .rd_data(cmd),
    .empty  (q_empty)
  );

  assign cmd_valid = !q_empty;

endmodule

// ----- hdl/tpbc_back.sv -----
// Back end: barrier phase machine, seen mask, tick counter and result queue.
// Depends on tpbc_pkg and tpbc_fifo.
module tpbc_back
  import tpbc_pkg::*;
#(
  parameter int unsigned NODE_LIMIT = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  phase_t                phase_r, phase_nxt;
  logic [NODE_LIMIT-1:0] mask_r, mask_nxt;
  logic [31:0]           ticks_r, ticks_nxt;
  logic [31:0]           epoch_r, epoch_nxt;

  logic                  res_full, emit;
  out_item_t             res;
  logic [NODE_LIMIT-1:0] need, msg_mask, own_mask;
  logic [31:0]           ticks_inc;
  logic                  type_ok;

  function automatic logic [NODE_LIMIT-1:0] node_bit(input logic [3:0] n);
    logic [NODE_LIMIT-1:0] b;
    for (int i = 0; i < NODE_LIMIT; i++) begin
      b[i] = (32'(i) == 32'(n));
    end
    return b;
  endfunction

  always_comb begin
    for (int i = 0; i < NODE_LIMIT; i++) begin
      need[i] = (32'(i) < 32'(cfg.node_count));
    end
  end

  assign cmd_pop   = cmd_valid && !res_full;
  assign msg_mask  = mask_r | node_bit(cmd.sender);
  assign own_mask  = node_bit(cfg.node_id);
  assign ticks_inc = (ticks_r == '1) ? ticks_r : ticks_r + 32'd1;
  assign type_ok   = ((phase_r == PH_COLL_ANN) && (cmd.message_type == MSG_ANN)) ||
                     ((phase_r == PH_COLL_ACK) && (cmd.message_type == MSG_ACK));

  always_comb begin
    phase_nxt = phase_r;
    mask_nxt  = mask_r;
    ticks_nxt = ticks_r;
    epoch_nxt = epoch_r;
    emit      = 1'b0;
    res       = '0;
    if (cmd_pop) begin
      case (cmd.op)
        OP_START: begin
          if (phase_r == PH_IDLE) begin
            epoch_nxt           = cmd.epoch;
            phase_nxt           = PH_SEND_ANN;
            emit                = 1'b1;
            res.action          = ACT_REQUEST;
            res.broadcast_type  = MSG_ANN;
            res.broadcast_epoch = cmd.epoch;
          end
        end
        OP_MSG: begin
          if (type_ok && (cmd.epoch == epoch_r)) begin
            mask_nxt = msg_mask;
            if ((msg_mask & need) == need) begin
              emit = 1'b1;
              if (phase_r == PH_COLL_ANN) begin
                phase_nxt           = PH_SEND_ACK;
                res.action          = ACT_REQUEST;
                res.broadcast_type  = MSG_ACK;
                res.broadcast_epoch = epoch_r;
              end else begin
                phase_nxt   = PH_IDLE;
                res.action  = ACT_FINISH;
                res.success = 1'b1;
              end
            end
          end
        end
        OP_TICK: begin
          if ((phase_r == PH_COLL_ANN) || (phase_r == PH_COLL_ACK)) begin
            ticks_nxt = ticks_inc;
            if (ticks_inc > cfg.timeout_ticks) begin
              emit           = 1'b1;
              phase_nxt      = PH_IDLE;
              res.action     = ACT_FINISH;
              res.fail_cause = CAUSE_TIMEOUT;
            end
          end
        end
        OP_SEND: begin
          if ((phase_r == PH_SEND_ANN) || (phase_r == PH_SEND_ACK)) begin
            if (!cmd.send_ok) begin
              emit           = 1'b1;
              phase_nxt      = PH_IDLE;
              res.action     = ACT_FINISH;
              res.fail_cause = CAUSE_SEND;
            end else begin
              mask_nxt  = own_mask;
              ticks_nxt = '0;
              phase_nxt = (phase_r == PH_SEND_ANN) ? PH_COLL_ANN : PH_COLL_ACK;
              // own bit alone may already complete the phase
              if ((own_mask & need) == need) begin
                emit = 1'b1;
                if (phase_r == PH_SEND_ANN) begin
                  phase_nxt           = PH_SEND_ACK;
                  res.action          = ACT_REQUEST;
                  res.broadcast_type  = MSG_ACK;
                  res.broadcast_epoch = epoch_r;
                end else begin
                  phase_nxt   = PH_IDLE;
                  res.action  = ACT_FINISH;
                  res.success = 1'b1;
                end
              end
            end
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      mask_r  <= '0;
      ticks_r <= '0;
      epoch_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      mask_r  <= mask_nxt;
      ticks_r <= ticks_nxt;
      epoch_r <= epoch_nxt;
    end
  end

  tpbc_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(Q_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (emit),
    .wr_data(res),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(out_data),
    .empty  (empty)
  );

endmodule

// ----- hdl/two_phase_barrier_controller.sv -----
// Two-phase barrier controller, node side: top level.
// Depends on tpbc_pkg, tpbc_cfg, tpbc_front, tpbc_back.
//
// Takes one beat per cycle on the in_ side unless the front queue is full.
// The front queues decoded beats in a two-entry queue; the back runs the
// barrier phase machine on one command per cycle and writes any broadcast
// request or finish report into a two-entry result queue, so a result passes
// both queues before it shows on the out_ side. The back stops only while
// the result queue is full. Seen mask is NODE_LIMIT bits; senders or node
// ids at or above it are dropped. Registers: node_id at 0x0, node_count at
// 0x4, timeout_ticks at 0x8; write only while no barrier is running.
module two_phase_barrier_controller
  import tpbc_pkg::*;
#(
  parameter int unsigned NODE_LIMIT = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_data,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;
  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  tpbc_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  tpbc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .cmd_pop  (cmd_pop),
    .cmd_valid(cmd_valid),
    .cmd      (cmd)
  );

  tpbc_back #(
    .NODE_LIMIT(NODE_LIMIT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

// ----- hdl/tpbc_checker.sv -----
// Port-level checks for the barrier controller, bound to the top level.
// Depends on tpbc_pkg and two_phase_barrier_controller.
module tpbc_props
  import tpbc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      empty,
  input logic      pop,
  input out_item_t out_data
);

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_request_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_data.action == ACT_REQUEST)) |->
      (!out_data.success && (out_data.fail_cause == CAUSE_NONE)))
    else $error("broadcast request carries finish fields");

  a_finish_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_data.action == ACT_FINISH)) |->
      ((out_data.success && (out_data.fail_cause == CAUSE_NONE)) ||
       (!out_data.success && ((out_data.fail_cause == CAUSE_SEND) ||
                              (out_data.fail_cause == CAUSE_TIMEOUT)))))
    else $error("finish success and cause disagree");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("stalled result beat changed");

endmodule

bind two_phase_barrier_controller tpbc_props u_tpbc_props (
  .clk     (clk),
  .rst_n   (rst_n),
  .empty   (empty),
  .pop     (pop),
  .out_data(out_data)
);

// ----- bench/tpbc_checker.sv -----
// Checker for the two-phase barrier controller: tracks the register file from the
// config bus, predicts barrier requests and finish reports, and compares result beats.
// Depends on tpbc_pkg.
module tpbc_checker
  import tpbc_pkg::*;
#(
  parameter int unsigned NODE_LIMIT = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic                  full,
  input  in_item_t              in_data,
  input  logic                  empty,
  input  logic                  pop,
  input  out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic [CFG_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    result_count,
  output int                    reports_due,
  output phase_t                barrier_phase,
  output logic [31:0]           barrier_epoch
);

  cfg_t                  regs;
  phase_t                ph;
  logic [NODE_LIMIT-1:0] seen;
  logic [31:0]           ticks;
  logic [31:0]           epoch;
  out_item_t             pending_reports[$];

  initial begin
    fail_count    = 0;
    result_count  = 0;
    reports_due   = 0;
    barrier_phase = PH_IDLE;
    barrier_epoch = '0;
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  function automatic logic [31:0] reg_value(input logic [1:0] idx);
    case (idx)
      REG_NODE_ID:    return {28'd0, regs.node_id};
      REG_NODE_COUNT: return {27'd0, regs.node_count};
      REG_TIMEOUT:    return regs.timeout_ticks;
      default:        return '0;
    endcase
  endfunction

  function automatic logic [NODE_LIMIT-1:0] node_mask(input logic [3:0] n);
    logic [NODE_LIMIT-1:0] b;
    b = '0;
    if (n < NODE_LIMIT) b[n] = 1'b1;
    return b;
  endfunction

  function automatic logic quorum_met();
    int unsigned      n;
    logic [NODE_LIMIT:0] need;
    n = (regs.node_count > NODE_LIMIT) ? NODE_LIMIT : regs.node_count;
    need = ({{NODE_LIMIT{1'b0}}, 1'b1} << n) - 1'b1;
    return (seen & need[NODE_LIMIT-1:0]) == need[NODE_LIMIT-1:0];
  endfunction

  function automatic out_item_t request(input logic mtype);
    out_item_t r;
    r = '0;
    r.action          = ACT_REQUEST;
    r.broadcast_type  = mtype;
    r.broadcast_epoch = epoch;
    return r;
  endfunction

  function automatic out_item_t finish(input logic ok, input logic [1:0] cause);
    out_item_t r;
    ph = PH_IDLE;
    r = '0;
    r.action     = ACT_FINISH;
    r.success    = ok;
    r.fail_cause = cause;
    return r;
  endfunction

  function automatic logic close_round(output out_item_t res);
    if (!quorum_met()) return 1'b0;
    if (ph == PH_COLL_ANN) begin
      ph = PH_SEND_ACK;
      res = request(MSG_ACK);
    end else begin
      res = finish(1'b1, CAUSE_NONE);
    end
    return 1'b1;
  endfunction

  // one accepted beat; returns 1 when it yields a result
  function automatic logic barrier_step(input in_item_t it, output out_item_t res);
    logic want;
    case (it.kind)
      KIND_START: begin
        if (ph != PH_IDLE) return 1'b0;
        epoch = it.epoch;
        ph = PH_SEND_ANN;
        res = request(MSG_ANN);
        return 1'b1;
      end
      KIND_MSG: begin
        if (ph == PH_COLL_ANN) want = MSG_ANN;
        else if (ph == PH_COLL_ACK) want = MSG_ACK;
        else return 1'b0;
        if (it.epoch != epoch || it.message_type != want) return 1'b0;
        seen |= node_mask(it.sender);
        return close_round(res);
      end
      KIND_TICK: begin
        if (ph != PH_COLL_ANN && ph != PH_COLL_ACK) return 1'b0;
        if (ticks != '1) ticks++;
        if (ticks > regs.timeout_ticks) begin
          res = finish(1'b0, CAUSE_TIMEOUT);
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        if (ph != PH_SEND_ANN && ph != PH_SEND_ACK) return 1'b0;
        if (!it.send_ok) begin
          res = finish(1'b0, CAUSE_SEND);
          return 1'b1;
        end
        if (ph == PH_SEND_ANN) ph = PH_COLL_ANN;
        else ph = PH_COLL_ACK;
        seen  = node_mask(regs.node_id);
        ticks = '0;
        return close_round(res);
      end
    endcase
  endfunction

  always @(posedge clk) begin : watch
    out_item_t res;
    out_item_t want_res;
    if (!rst_n) begin
      regs.node_id       = RST_NODE_ID;
      regs.node_count    = RST_NODE_COUNT;
      regs.timeout_ticks = RST_TIMEOUT;
      ph    = PH_IDLE;
      seen  = '0;
      ticks = '0;
      epoch = '0;
      pending_reports.delete();
    end else begin
      if (pop && !empty) begin
        if (pending_reports.size() == 0) begin
          note_failure($sformatf("result %0d: beat with none expected", result_count));
        end else begin
          want_res = pending_reports.pop_front();
          if (want_res.action !== out_data.action ||
              want_res.broadcast_type !== out_data.broadcast_type ||
              want_res.broadcast_epoch !== out_data.broadcast_epoch ||
              want_res.success !== out_data.success ||
              want_res.fail_cause !== out_data.fail_cause)
            note_failure($sformatf(
              "result %0d: exp act %0d typ %0d ep %h ok %0d cause %0d, got %0d %0d %h %0d %0d",
              result_count, want_res.action, want_res.broadcast_type,
              want_res.broadcast_epoch, want_res.success, want_res.fail_cause,
              out_data.action, out_data.broadcast_type, out_data.broadcast_epoch,
              out_data.success, out_data.fail_cause));
        end
        result_count++;
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[CFG_ADDR_W-1:2])
            REG_NODE_ID:    regs.node_id = pwdata[3:0];
            REG_NODE_COUNT: regs.node_count = pwdata[4:0];
            REG_TIMEOUT:    regs.timeout_ticks = pwdata[31:0];
            default: ;
          endcase
        end else if (prdata !== reg_value(paddr[CFG_ADDR_W-1:2])) begin
          note_failure($sformatf("register read at %h: exp %h, got %h",
                                 paddr, reg_value(paddr[CFG_ADDR_W-1:2]), prdata));
        end
      end
      if (push && !full) begin
        if (barrier_step(in_data, res)) pending_reports.push_back(res);
      end
    end
    reports_due   <= pending_reports.size();
    barrier_phase <= ph;
    barrier_epoch <= epoch;
  end

endmodule

// ----- bench/tb.sv -----
// Testbench top for the two-phase barrier controller: clock, reset, bursty stimulus,
// stalling receiver, config writes between barriers, watchdog and verdict.
// Depends on tpbc_pkg, two_phase_barrier_controller and tpbc_checker.
module tb
  import tpbc_pkg::*;
();

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 8;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  push = 1'b0;
  in_item_t              in_data = '0;
  logic                  pop = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic                  full;
  logic                  empty;
  out_item_t             out_data;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int          fail_count;
  int          result_count;
  int          reports_due;
  phase_t      barrier_phase;
  logic [31:0] barrier_epoch;

  int          sent_beats = 0;
  int          burst_left = 0;
  int          wr_count = 16;
  int          tick_pct = 10;
  int          idle_cycles = 0;
  int          stall_left = 0;
  int          rx_mode = 0;
  int          rx_cycle = 0;
  logic [3:0]  closing_sender = '0;

  two_phase_barrier_controller u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  tpbc_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_data       (in_data),
    .empty         (empty),
    .pop           (pop),
    .out_data      (out_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .result_count  (result_count),
    .reports_due   (reports_due),
    .barrier_phase (barrier_phase),
    .barrier_epoch (barrier_epoch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: free-running, short-stall and long-stall modes
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 2);
      if (stall_left != 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        case (rx_mode)
          1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
          2: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 40);
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("FAIL two_phase_barrier_controller");
        $finish;
      end
    end
  end

  function automatic in_item_t beat(input logic [1:0] kind, input logic [31:0] ep,
                                    input logic [3:0] snd, input logic mt, input logic ok);
    in_item_t it;
    it.kind         = kind;
    it.epoch        = ep;
    it.sender       = snd;
    it.message_type = mt;
    it.send_ok      = ok;
    return it;
  endfunction

  function automatic in_item_t noise_beat();
    return beat(2'($urandom_range(0, 3)), $urandom, 4'($urandom_range(0, 15)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  task automatic send_beat(input in_item_t it);
    in_data <= it;
    push    <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    sent_beats++;
    if (burst_left == 0) begin
      push <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 30)) @(posedge clk);
      else repeat ($urandom_range(1, 4)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic cfg_access(input logic wr, input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [3:0] id, input logic [4:0] cnt,
                            input logic [31:0] tmo);
    cfg_access(1'b1, REG_NODE_ID, {28'd0, id});
    cfg_access(1'b1, REG_NODE_COUNT, {27'd0, cnt});
    cfg_access(1'b1, REG_TIMEOUT, tmo);
    cfg_access(1'b0, REG_NODE_ID, '0);
    cfg_access(1'b0, REG_NODE_COUNT, '0);
    cfg_access(1'b0, REG_TIMEOUT, '0);
    wr_count = cnt;
  endtask

  // drain results and close any open barrier, then let the pipe empty
  task automatic settle();
    in_item_t it;
    push <= 1'b0;
    @(posedge clk);
    forever begin
      while (reports_due != 0) @(posedge clk);
      if (barrier_phase == PH_IDLE) break;
      case (barrier_phase)
        PH_COLL_ANN: it = beat(KIND_MSG, barrier_epoch, closing_sender, MSG_ANN, 1'b0);
        PH_COLL_ACK: it = beat(KIND_MSG, barrier_epoch, closing_sender, MSG_ACK, 1'b0);
        default:     it = beat(KIND_SEND, $urandom, 4'd0, MSG_ANN, 1'b0);
      endcase
      closing_sender++;
      send_beat(it);
      push <= 1'b0;
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic collect_round(input logic [31:0] ep, input logic mtype);
    int          order[16];
    int          n;
    int          k;
    int          j;
    int          t;
    logic [31:0] mep;
    logic [3:0]  snd;
    n = (wr_count > 16) ? 16 : wr_count;
    for (k = 0; k < 16; k++) order[k] = k;
    for (k = n - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    for (k = 0; k < n + 2; k++) begin
      if ($urandom_range(0, 99) < tick_pct)
        send_beat(beat(KIND_TICK, $urandom, 4'($urandom_range(0, 15)), 1'b0, 1'b0));
      if ($urandom_range(0, 99) < 8) send_beat(noise_beat());
      mep = ($urandom_range(0, 9) == 0) ? ep ^ (32'd1 << $urandom_range(0, 31)) : ep;
      snd = (k < n) ? 4'(order[k]) : 4'($urandom_range(0, 15));
      send_beat(beat(KIND_MSG, mep, snd,
                     ($urandom_range(0, 9) == 0) ? ~mtype : mtype,
                     1'($urandom_range(0, 1))));
    end
  endtask

  task automatic run_barrier();
    logic [31:0] ep;
    case ($urandom_range(0, 7))
      0:       ep = '0;
      1:       ep = '1;
      default: ep = $urandom;
    endcase
    send_beat(beat(KIND_START, ep, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1))));
    if ($urandom_range(0, 9) == 0) send_beat(beat(KIND_START, $urandom, 4'd0, 1'b0, 1'b1));
    send_beat(beat(KIND_SEND, $urandom, 4'd0, 1'b0, $urandom_range(0, 9) != 0));
    collect_round(ep, MSG_ANN);
    send_beat(beat(KIND_SEND, $urandom, 4'd0, 1'b0, $urandom_range(0, 9) != 0));
    collect_round(ep, MSG_ACK);
    if ($urandom_range(0, 3) != 0) settle();
  endtask

  initial begin
    int start_beats;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_access(1'b0, REG_NODE_ID, '0);
    cfg_access(1'b0, REG_NODE_COUNT, '0);
    cfg_access(1'b0, REG_TIMEOUT, '0);

    // directed: node 3 of 4, timeout on the fourth tick of a collect phase
    set_config(4'd3, 5'd4, 32'd3);
    send_beat(beat(KIND_MSG, 32'd0, 4'd0, MSG_ANN, 1'b0));
    send_beat(beat(KIND_TICK, 32'd0, 4'd0, MSG_ANN, 1'b0));
    send_beat(beat(KIND_SEND, 32'd0, 4'd0, MSG_ANN, 1'b1));
    send_beat(beat(KIND_START, 32'hFFFF_FFFF, 4'd15, MSG_ACK, 1'b1));
    send_beat(beat(KIND_START, 32'd1, 4'd0, MSG_ANN, 1'b0));
    send_beat(beat(KIND_MSG, 32'hFFFF_FFFF, 4'd0, MSG_ANN, 1'b0));
    send_beat(beat(KIND_SEND, 32'd0, 4'd0, MSG_ANN, 1'b1));
    send_beat(beat(KIND_MSG, 32'hFFFF_FFFE, 4'd0, MSG_ANN, 1'b0));
    send_beat(beat(KIND_MSG, 32'hFFFF_FFFF, 4'd0, MSG_ACK, 1'b0));
    send_beat(beat(KIND_MSG, 32'hFFFF_FFFF, 4'd15, MSG_ANN, 1'b0));
    send_beat(beat(KIND_MSG, 32'hFFFF_FFFF, 4'd0, MSG_ANN, 1'b0));
    send_beat(beat(KIND_TICK, 32'd0, 4'd0, MSG_ANN, 1'b0));
    send_beat(beat(KIND_MSG, 32'hFFFF_FFFF, 4'd1, MSG_ANN, 1'b0));
    send_beat(beat(KIND_MSG, 32'hFFFF_FFFF, 4'd2, MSG_ANN, 1'b0));
    send_beat(beat(KIND_SEND, 32'd0, 4'd0, MSG_ANN, 1'b1));
    send_beat(beat(KIND_MSG, 32'hFFFF_FFFF, 4'd2, MSG_ACK, 1'b1));
    send_beat(beat(KIND_MSG, 32'hFFFF_FFFF, 4'd1, MSG_ACK, 1'b1));
    send_beat(beat(KIND_MSG, 32'hFFFF_FFFF, 4'd0, MSG_ACK, 1'b1));
    send_beat(beat(KIND_START, 32'd0, 4'd0, MSG_ANN, 1'b0));
    send_beat(beat(KIND_SEND, 32'd0, 4'd0, MSG_ANN, 1'b0));
    send_beat(beat(KIND_START, 32'h5A5A_5A5A, 4'd0, MSG_ANN, 1'b0));
    send_beat(beat(KIND_SEND, 32'd0, 4'd0, MSG_ANN, 1'b1));
    repeat (4) send_beat(beat(KIND_TICK, 32'd0, 4'd0, MSG_ANN, 1'b0));
    settle();

    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: set_config(4'd0, 5'd16, 32'hFFFF_FFFF);
        1: set_config(4'd15, 5'd1, 32'd0);
        2: set_config(4'($urandom_range(0, 15)), 5'd0, 32'd5);
        3: set_config(4'($urandom_range(0, 15)), 5'd31, 32'd1000000);
        4: set_config(4'($urandom_range(0, 15)), 5'd17, 32'd20);
        5: set_config(4'($urandom_range(0, 15)), 5'($urandom_range(2, 8)),
                      $urandom_range(3, 30));
        6: set_config(4'($urandom_range(0, 15)), 5'($urandom_range(1, 16)),
                      $urandom_range(0, 40));
        default: set_config(4'd7, 5'd4, 32'd12);
      endcase
      tick_pct = $urandom_range(0, 30);
      start_beats = sent_beats;
      while (sent_beats < start_beats + 250) run_barrier();
    end
    settle();

    $display("Sent %0d input beats and checked %0d result beats over eight register settings,",
             sent_beats, result_count);
    $display("with send failures, timeouts, stray messages and early completion mixed in.");
    if (fail_count == 0) $display("PASS two_phase_barrier_controller");
    else $display("FAIL two_phase_barrier_controller");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/tpbc_pkg.sv
hdl/tpbc_fifo.sv
hdl/tpbc_cfg.sv
hdl/tpbc_front.sv
hdl/tpbc_back.sv
hdl/two_phase_barrier_controller.sv
hdl/tpbc_checker.sv
bench/tpbc_checker.sv
bench/tb.sv
